[design/lut_color_grade_3d_core_macros.svh]
// ----------------------------------------------------------------------------
// lut_color_grade_3d_core assertion macros
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef LUT_COLOR_GRADE_3D_CORE_MACROS_SVH
`define LUT_COLOR_GRADE_3D_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LCG3D_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (1'b1) |-> (cond)) \
        else $error(msg);
`define LCG3D_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define LCG3D_ASSERT_ALWAYS(label, cond, msg)
`define LCG3D_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

[design/lcg3d_pkg.sv]
// ----------------------------------------------------------------------------
// lcg3d_pkg
// Types, constants and arithmetic helpers for the 3D color table grader.
// ----------------------------------------------------------------------------
package lcg3d_pkg;

    localparam int PIX_W           = 8;
    localparam int GRID_POINTS     = 32;
    localparam int ENTRY_FRAC_BITS = 12;
    localparam int GRID_W          = $clog2(GRID_POINTS);
    localparam int CELL_W          = PIX_W - GRID_W;
    localparam int CELL            = 1 << CELL_W;
    localparam int WT_W            = CELL_W + 1;
    localparam int ENTRY_W         = ENTRY_FRAC_BITS + 1;
    localparam int ADDR_W          = 3 * GRID_W;
    localparam int TABLE_DEPTH     = 1 << ADDR_W;
    localparam int NUM_W           = ENTRY_W + CELL_W;
    localparam int SCALE_W         = NUM_W + PIX_W;
    localparam int SHIFT_W         = CELL_W + ENTRY_FRAC_BITS;
    localparam int Q_W             = SCALE_W - SHIFT_W;
    localparam int PIX_MAX         = (1 << PIX_W) - 1;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = QPTR_W + 1;

    localparam logic [GRID_W-1:0] GRID_LAST = GRID_W'(GRID_POINTS - 1);
    localparam logic [GRID_W-1:0] GRID_TOP  = GRID_W'(GRID_POINTS - 2);

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_PIXEL = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t               cmd;
        logic [ADDR_W-1:0]  entry_index;
        logic [ENTRY_W-1:0] entry_red;
        logic [ENTRY_W-1:0] entry_green;
        logic [ENTRY_W-1:0] entry_blue;
        logic [PIX_W-1:0]   pixel_red;
        logic [PIX_W-1:0]   pixel_green;
        logic [PIX_W-1:0]   pixel_blue;
    } req_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] graded_red;
        logic [PIX_W-1:0] graded_green;
        logic [PIX_W-1:0] graded_blue;
    } rsp_t;

    typedef struct packed
    {
        logic [ENTRY_W-1:0] red;
        logic [ENTRY_W-1:0] green;
        logic [ENTRY_W-1:0] blue;
    } entry_t;

    // addr_a: write address or start corner, addr_b: end corner
    typedef struct packed
    {
        cmd_t              cmd;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        entry_t            entry;
        logic [CELL_W-1:0] frac_red;
        logic [CELL_W-1:0] frac_green;
        logic [CELL_W-1:0] frac_blue;
    } op_t;

    typedef struct packed
    {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_stat_t;

    function automatic logic [GRID_W-1:0] grid_index(input logic [PIX_W-1:0] px);
        logic [GRID_W-1:0] gi;
        gi = px[PIX_W-1 -: GRID_W];
        if (gi >= GRID_LAST)
        begin
            gi = GRID_TOP;
        end
        return gi;
    endfunction

    function automatic logic [NUM_W-1:0] lerp_num(input logic [ENTRY_W-1:0] s,
                                                  input logic [ENTRY_W-1:0] e,
                                                  input logic [CELL_W-1:0]  f);
        logic [WT_W-1:0] wt_s;
        wt_s = WT_W'(CELL) - WT_W'(f);
        return NUM_W'(s) * NUM_W'(wt_s) + NUM_W'(e) * NUM_W'(f);
    endfunction

    function automatic logic [PIX_W-1:0] grade(input logic [NUM_W-1:0] num);
        logic [SCALE_W-1:0] sc;
        logic [Q_W-1:0]     q;
        sc = (SCALE_W'(num) << PIX_W) - SCALE_W'(num);
        q  = sc[SCALE_W-1:SHIFT_W];
        return (q > Q_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : q[PIX_W-1:0];
    endfunction

endpackage

[design/lcg3d_front.sv]
// ----------------------------------------------------------------------------
// lcg3d_front
// Request intake: classifies write and pixel requests, forms table addresses.
// ----------------------------------------------------------------------------
module lcg3d_front
    import lcg3d_pkg::*;
(
    input  logic        req_valid,
    input  req_t        req_data,
    output logic        req_stall,
    input  queue_stat_t q_stat,
    output logic        push,
    output op_t         push_op
);

    logic [GRID_W-1:0] gi_red;
    logic [GRID_W-1:0] gi_green;
    logic [GRID_W-1:0] gi_blue;

    assign req_stall = q_stat.full;
    assign push      = req_valid && !q_stat.full;

    always_comb
    begin
        gi_red   = grid_index(req_data.pixel_red);
        gi_green = grid_index(req_data.pixel_green);
        gi_blue  = grid_index(req_data.pixel_blue);

        push_op.cmd        = req_data.cmd;
        push_op.entry      = '{red:   req_data.entry_red,
                               green: req_data.entry_green,
                               blue:  req_data.entry_blue};
        push_op.frac_red   = req_data.pixel_red[CELL_W-1:0];
        push_op.frac_green = req_data.pixel_green[CELL_W-1:0];
        push_op.frac_blue  = req_data.pixel_blue[CELL_W-1:0];
        push_op.addr_b     = {gi_blue + GRID_W'(1), gi_green + GRID_W'(1),
                              gi_red + GRID_W'(1)};
        unique case (req_data.cmd)
            CMD_WRITE:
            begin
                push_op.addr_a = req_data.entry_index;
            end
            CMD_PIXEL:
            begin
                push_op.addr_a = {gi_blue, gi_green, gi_red};
            end
            default:
            begin
                push_op.addr_a = req_data.entry_index;
            end
        endcase
    end

endmodule

[design/lcg3d_queue.sv]
// ----------------------------------------------------------------------------
// lcg3d_queue
// Small FIFO of decoded operations between intake and table pipeline.
// ----------------------------------------------------------------------------
module lcg3d_queue
    import lcg3d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  op_t         push_op,
    input  logic        pop,
    output op_t         pop_op,
    output queue_stat_t q_stat
);

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign pop_op       = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.count = count_reg;

endmodule

[design/lcg3d_back.sv]
// ----------------------------------------------------------------------------
// lcg3d_back
// Table storage and interpolation pipeline: write or dual read, blend, scale.
// ----------------------------------------------------------------------------
module lcg3d_back
    import lcg3d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_stat_t q_stat,
    input  op_t         pop_op,
    output logic        pop,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp_data
);

    entry_t            table_mem [TABLE_DEPTH];

    logic              adv;
    logic              s1_valid_reg;
    logic [CELL_W-1:0] s1_frac_red_reg;
    logic [CELL_W-1:0] s1_frac_green_reg;
    logic [CELL_W-1:0] s1_frac_blue_reg;
    entry_t            rd_start_reg;
    entry_t            rd_end_reg;
    logic              s2_valid_reg;
    logic [NUM_W-1:0]  s2_num_red_reg;
    logic [NUM_W-1:0]  s2_num_green_reg;
    logic [NUM_W-1:0]  s2_num_blue_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_data_reg;

    assign adv = !(rsp_valid_reg && rsp_stall);
    assign pop = adv && !q_stat.empty;

    always_ff @(posedge clk)
    begin
        if (pop && (pop_op.cmd == CMD_WRITE))
        begin
            table_mem[pop_op.addr_a] <= pop_op.entry;
        end
        if (adv)
        begin
            rd_start_reg <= table_mem[pop_op.addr_a];
            rd_end_reg   <= table_mem[pop_op.addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop && (pop_op.cmd == CMD_PIXEL);
            s2_valid_reg  <= s1_valid_reg;
            rsp_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_frac_red_reg   <= pop_op.frac_red;
            s1_frac_green_reg <= pop_op.frac_green;
            s1_frac_blue_reg  <= pop_op.frac_blue;

            s2_num_red_reg   <= lerp_num(rd_start_reg.red, rd_end_reg.red,
                                         s1_frac_red_reg);
            s2_num_green_reg <= lerp_num(rd_start_reg.green, rd_end_reg.green,
                                         s1_frac_green_reg);
            s2_num_blue_reg  <= lerp_num(rd_start_reg.blue, rd_end_reg.blue,
                                         s1_frac_blue_reg);

            rsp_data_reg.graded_red   <= grade(s2_num_red_reg);
            rsp_data_reg.graded_green <= grade(s2_num_green_reg);
            rsp_data_reg.graded_blue  <= grade(s2_num_blue_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

[design/lut_color_grade_3d_core.sv]
// ----------------------------------------------------------------------------
// lut_color_grade_3d_core
// A pixel request passes the queue, table read, blend and result registers.
// Throughput: one request per cycle; the dual-read table port and the 4-entry
// operation queue set the rate, and a stalled result holds the table pipeline.
// Reset: asynchronous, clears queue and pipeline control; table content is
// undefined until written.
// ----------------------------------------------------------------------------
`include "lut_color_grade_3d_core_macros.svh"

module lut_color_grade_3d_core
    import lcg3d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    queue_stat_t q_stat;
    logic        push;
    op_t         push_op;
    logic        pop;
    op_t         pop_op;

    lcg3d_front u_front
    (
        .req_valid (req_valid),
        .req_data  (req_data),
        .req_stall (req_stall),
        .q_stat    (q_stat),
        .push      (push),
        .push_op   (push_op)
    );

    lcg3d_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .q_stat  (q_stat)
    );

    lcg3d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .pop_op    (pop_op),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    `LCG3D_ASSERT_ALWAYS(a_count_bound, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "queue overflow")
    `LCG3D_ASSERT_ALWAYS(a_pop_nonempty, !pop || !q_stat.empty, "pop from empty queue")
    `LCG3D_ASSERT_NEXT(a_push_count, push && !pop, q_stat.count == $past(q_stat.count) + QCNT_W'(1), "push lost")

endmodule
